// ===== rtl/core/cnest_pkg.sv =====
// Package for the conditional nesting tracker: stack sizing, directive,
// branch mark and error codes, and the packed input and result words.
// Depends on nothing; used by the tracker top level and its testbench.
package cnest_pkg;

  // Deepest nesting held on the branch mark stack (4 to 255).
  localparam int NEST_DEPTH = 128;
  // Stack pointer and false level counter widths (both can reach NEST_DEPTH).
  localparam int STACK_W = 8;
  // Address width of the branch mark memory.
  localparam int ADDR_W = $clog2(NEST_DEPTH);
  localparam int MARK_W = 2;
  localparam int LINE_W = 24;
  localparam int MLINE_W = 25;

  // Directive codes.
  typedef enum logic [2:0] {
    CMD_IF     = 3'd0,
    CMD_IFDEF  = 3'd1,
    CMD_IFNDEF = 3'd2,
    CMD_ELIF   = 3'd3,
    CMD_ELSE   = 3'd4,
    CMD_ENDIF  = 3'd5,
    CMD_OTHER  = 3'd6,
    CMD_EOF    = 3'd7
  } cmd_t;

  // Branch marks: never taken, already taken, taken.
  typedef enum logic [MARK_W-1:0] {
    MARK_U = 2'd0,
    MARK_N = 2'd1,
    MARK_D = 2'd2
  } mark_t;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_NAME  = 3'd1,
    ERR_ELIF  = 3'd2,
    ERR_ELSE  = 3'd3,
    ERR_ENDIF = 3'd4,
    ERR_OPEN  = 3'd5,
    ERR_OVER  = 3'd6
  } err_t;

  // One directive word.
  typedef struct packed {
    logic [2:0]        cmd;
    logic              cond;
    logic              name_ok;
    logic [LINE_W-1:0] line_number;
  } dir_word_t;

  // One result word.
  typedef struct packed {
    logic               active;
    logic               emit_newline;
    logic               emit_marker;
    logic [MLINE_W-1:0] marker_line;
    logic [2:0]         error_code;
  } res_word_t;

endpackage

// ===== rtl/core/cnest_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing; holds the branch marks below the top of the stack.
module cnest_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/conditional_nesting_tracker.sv =====
// Top level of the conditional nesting tracker: branch mark stack with the
// top mark in a register, the rest in cnest_ram, and a false level counter.
// Depends on cnest_pkg and cnest_ram.
//
//   Channel  Direction  Handshake            Word type
//   dir      in         dir_valid/dir_stall  cnest_pkg::dir_word_t
//   res      out        res_valid/res_stall  cnest_pkg::res_word_t
//
// One directive word is taken per cycle unless the input is stalled; its
// result word is registered when it is accepted. The top branch mark lives
// in a register and the mark below it is prefetched from the RAM read port,
// so pushes and pops follow each other without gaps. rst clears the stack
// pointer, the false level count and the result valid flag. The input is
// stalled only while a result word waits and the output is stalled.
module conditional_nesting_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 dir_valid,
  output logic                 dir_stall,
  input  cnest_pkg::dir_word_t dir_word,
  output logic                 res_valid,
  input  logic                 res_stall,
  output cnest_pkg::res_word_t res_word
);

  // Stack state.
  logic [cnest_pkg::STACK_W-1:0] stack_top, stack_top_next;
  logic [cnest_pkg::STACK_W-1:0] false_count, false_count_next;
  cnest_pkg::mark_t              top_mark, top_mark_next;
  // Forwarding of a mark written while the same address is being read.
  logic                          byp_valid;
  cnest_pkg::mark_t              byp_mark;

  logic                          accept;
  logic                          wr_en;
  logic [cnest_pkg::ADDR_W-1:0]  wr_addr;
  logic [cnest_pkg::ADDR_W-1:0]  rd_addr;
  logic [cnest_pkg::MARK_W-1:0]  rd_data;
  cnest_pkg::mark_t              below_mark;
  logic [cnest_pkg::STACK_W-1:0] upd_top, upd_false;
  cnest_pkg::mark_t              upd_mark;
  logic                          upd_push;
  logic [cnest_pkg::STACK_W-1:0] false_dec;
  logic                          is_full;
  logic                          is_empty;
  logic                          hit;
  cnest_pkg::res_word_t          res_calc;
  logic [cnest_pkg::MLINE_W-1:0] line_next;

  // Input is held off only while the result register is full and stalled.
  assign dir_stall = res_valid && res_stall;
  assign accept    = dir_valid && !dir_stall;

  assign below_mark = byp_valid ? byp_mark : cnest_pkg::mark_t'(rd_data);
  assign is_full    = (stack_top == cnest_pkg::STACK_W'(cnest_pkg::NEST_DEPTH));
  assign is_empty   = (stack_top == '0);
  assign false_dec  = (false_count != '0) ? false_count - 1'b1 : '0;
  assign line_next  = {1'b0, dir_word.line_number} + 1'b1;

  // Directive decode: next stack state and the result word.
  always_comb begin
    upd_top   = stack_top;
    upd_false = false_count;
    upd_mark  = top_mark;
    upd_push  = 1'b0;
    hit       = 1'b0;
    res_calc  = '0;
    res_calc.active     = (false_count == '0);
    res_calc.error_code = cnest_pkg::ERR_NONE;
    unique case (cnest_pkg::cmd_t'(dir_word.cmd))
      cnest_pkg::CMD_IF: begin
        if (is_full) begin
          res_calc.error_code = cnest_pkg::ERR_OVER;
        end else begin
          upd_push = 1'b1;
          if (res_calc.active && dir_word.cond) begin
            upd_mark = cnest_pkg::MARK_D;
            res_calc.emit_newline = 1'b1;
          end else begin
            upd_mark  = cnest_pkg::MARK_U;
            upd_false = false_count + 1'b1;
          end
        end
      end
      cnest_pkg::CMD_IFDEF, cnest_pkg::CMD_IFNDEF: begin
        hit = (dir_word.cmd == cnest_pkg::CMD_IFDEF) ? dir_word.cond : !dir_word.cond;
        if (is_full) begin
          res_calc.error_code = cnest_pkg::ERR_OVER;
        end else if (!dir_word.name_ok) begin
          upd_push = 1'b1;
          upd_mark = cnest_pkg::MARK_D;
          res_calc.error_code = cnest_pkg::ERR_NAME;
        end else begin
          upd_push = 1'b1;
          if (hit) begin
            upd_mark = cnest_pkg::MARK_D;
            res_calc.emit_newline = res_calc.active;
          end else begin
            upd_mark  = cnest_pkg::MARK_U;
            upd_false = false_count + 1'b1;
          end
        end
      end
      cnest_pkg::CMD_ELIF: begin
        if (is_empty) begin
          res_calc.error_code = cnest_pkg::ERR_ELIF;
        end else if (top_mark == cnest_pkg::MARK_U) begin
          if (false_count == cnest_pkg::STACK_W'(1) && dir_word.cond) begin
            upd_mark  = cnest_pkg::MARK_D;
            upd_false = '0;
            res_calc.emit_marker = 1'b1;
            res_calc.marker_line = {1'b0, dir_word.line_number};
          end
        end else if (top_mark != cnest_pkg::MARK_N) begin
          upd_mark  = cnest_pkg::MARK_N;
          upd_false = false_count + 1'b1;
          res_calc.emit_newline = 1'b1;
        end
      end
      cnest_pkg::CMD_ELSE: begin
        if (is_empty) begin
          res_calc.error_code = cnest_pkg::ERR_ELSE;
        end else if (top_mark == cnest_pkg::MARK_U) begin
          upd_mark  = cnest_pkg::MARK_D;
          upd_false = false_dec;
          if (false_dec == '0) begin
            res_calc.emit_marker = 1'b1;
            res_calc.marker_line = line_next;
          end
        end else if (top_mark != cnest_pkg::MARK_N) begin
          upd_mark  = cnest_pkg::MARK_U;
          upd_false = false_count + 1'b1;
        end
      end
      cnest_pkg::CMD_ENDIF: begin
        if (is_empty) begin
          res_calc.error_code = cnest_pkg::ERR_ENDIF;
        end else begin
          upd_top  = stack_top - 1'b1;
          upd_mark = below_mark;
          if (top_mark == cnest_pkg::MARK_U || top_mark == cnest_pkg::MARK_N) begin
            upd_false = false_dec;
            if (false_dec == '0) begin
              res_calc.emit_marker = 1'b1;
              res_calc.marker_line = line_next;
            end
          end else begin
            res_calc.emit_newline = 1'b1;
          end
        end
      end
      cnest_pkg::CMD_EOF: begin
        if (!is_empty) begin
          res_calc.error_code = cnest_pkg::ERR_OPEN;
        end
      end
      default: begin
      end
    endcase
    if (upd_push) begin
      upd_top = stack_top + 1'b1;
    end
  end

  // A push moves the old top mark into the memory below the new top.
  assign wr_en   = accept && upd_push && !is_empty;
  assign wr_addr = cnest_pkg::ADDR_W'(stack_top - 1'b1);

  // Gate the state update on acceptance.
  always_comb begin
    stack_top_next   = stack_top;
    false_count_next = false_count;
    top_mark_next    = top_mark;
    if (accept) begin
      stack_top_next   = upd_top;
      false_count_next = upd_false;
      top_mark_next    = upd_mark;
    end
  end

  // Keep the mark just below the next top ready on the read port.
  assign rd_addr = cnest_pkg::ADDR_W'(stack_top_next - 2'd2);

  cnest_ram #(
    .WIDTH(cnest_pkg::MARK_W),
    .DEPTH(cnest_pkg::NEST_DEPTH)
  ) u_mark_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top_mark),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stack registers, forwarding register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top   <= '0;
      false_count <= '0;
      byp_valid   <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      stack_top   <= stack_top_next;
      false_count <= false_count_next;
      byp_valid   <= wr_en;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
    top_mark <= top_mark_next;
    byp_mark <= top_mark;
    if (accept) begin
      res_word <= res_calc;
    end
  end

endmodule

// ===== tb/tb_conditional_nesting_tracker.sv =====
// Self-checking testbench for conditional_nesting_tracker: directed and random
// directive streams with bursty input and a patterned output stall.
// Depends on cnest_pkg and the RTL of the tracker only.
module tb_conditional_nesting_tracker;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS,
    STALL_TOGGLE
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 dir_valid = 1'b0;
  logic                 dir_stall;
  cnest_pkg::dir_word_t dir_word = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  cnest_pkg::res_word_t res_word;

  // Words waiting to be sent, and results predicted but not yet seen.
  cnest_pkg::dir_word_t directive_queue[$];
  cnest_pkg::res_word_t expected_results[$];

  // Predicted tracker state.
  cnest_pkg::mark_t mark_stack[cnest_pkg::NEST_DEPTH];
  int               nest_level = 0;
  int               false_levels = 0;

  // Generator's view of the stack depth, used to shape the stream.
  int gen_depth = 0;

  int total_words = 0;
  int accepted_words = 0;
  int fail_count = 0;
  int cycle_count = 0;

  int          burst_left = 16;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          run_left = 0;
  logic        next_stall;

  conditional_nesting_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .dir_valid (dir_valid),
    .dir_stall (dir_stall),
    .dir_word  (dir_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicts the result of one directive and advances the predicted state.
  function automatic cnest_pkg::res_word_t predict_directive(cnest_pkg::dir_word_t d);
    cnest_pkg::res_word_t r;
    logic                 was_active;
    logic                 taken;
    cnest_pkg::mark_t     m;
    r = '0;
    was_active = (false_levels == 0);
    r.active = was_active;
    r.error_code = cnest_pkg::ERR_NONE;
    case (cnest_pkg::cmd_t'(d.cmd))
      cnest_pkg::CMD_IF: begin
        if (nest_level >= cnest_pkg::NEST_DEPTH) begin
          r.error_code = cnest_pkg::ERR_OVER;
        end else if (was_active && d.cond) begin
          mark_stack[nest_level] = cnest_pkg::MARK_D;
          nest_level++;
          r.emit_newline = 1'b1;
        end else begin
          mark_stack[nest_level] = cnest_pkg::MARK_U;
          nest_level++;
          false_levels++;
        end
      end
      cnest_pkg::CMD_IFDEF, cnest_pkg::CMD_IFNDEF: begin
        taken = (d.cmd == cnest_pkg::CMD_IFDEF) ? d.cond : !d.cond;
        if (nest_level >= cnest_pkg::NEST_DEPTH) begin
          r.error_code = cnest_pkg::ERR_OVER;
        end else if (!d.name_ok) begin
          // A missing identifier still opens a level, marked as taken.
          mark_stack[nest_level] = cnest_pkg::MARK_D;
          nest_level++;
          r.error_code = cnest_pkg::ERR_NAME;
        end else if (taken) begin
          mark_stack[nest_level] = cnest_pkg::MARK_D;
          nest_level++;
          r.emit_newline = was_active;
        end else begin
          mark_stack[nest_level] = cnest_pkg::MARK_U;
          nest_level++;
          false_levels++;
        end
      end
      cnest_pkg::CMD_ELIF: begin
        if (nest_level == 0) begin
          r.error_code = cnest_pkg::ERR_ELIF;
        end else begin
          m = mark_stack[nest_level-1];
          if (m == cnest_pkg::MARK_U) begin
            if (false_levels == 1 && d.cond) begin
              mark_stack[nest_level-1] = cnest_pkg::MARK_D;
              false_levels = 0;
              r.emit_marker = 1'b1;
              r.marker_line = cnest_pkg::MLINE_W'(d.line_number);
            end
          end else if (m != cnest_pkg::MARK_N) begin
            // A taken branch closes with a newline even in a false region.
            mark_stack[nest_level-1] = cnest_pkg::MARK_N;
            false_levels++;
            r.emit_newline = 1'b1;
          end
        end
      end
      cnest_pkg::CMD_ELSE: begin
        if (nest_level == 0) begin
          r.error_code = cnest_pkg::ERR_ELSE;
        end else begin
          m = mark_stack[nest_level-1];
          if (m == cnest_pkg::MARK_U) begin
            mark_stack[nest_level-1] = cnest_pkg::MARK_D;
            if (false_levels != 0) false_levels--;
            if (false_levels == 0) begin
              r.emit_marker = 1'b1;
              r.marker_line = cnest_pkg::MLINE_W'(d.line_number) + cnest_pkg::MLINE_W'(1);
            end
          end else if (m != cnest_pkg::MARK_N) begin
            mark_stack[nest_level-1] = cnest_pkg::MARK_U;
            false_levels++;
          end
        end
      end
      cnest_pkg::CMD_ENDIF: begin
        if (nest_level == 0) begin
          r.error_code = cnest_pkg::ERR_ENDIF;
        end else begin
          nest_level--;
          m = mark_stack[nest_level];
          if (m == cnest_pkg::MARK_U || m == cnest_pkg::MARK_N) begin
            if (false_levels != 0) false_levels--;
            if (false_levels == 0) begin
              r.emit_marker = 1'b1;
              r.marker_line = cnest_pkg::MLINE_W'(d.line_number) + cnest_pkg::MLINE_W'(1);
            end
          end else begin
            r.emit_newline = 1'b1;
          end
        end
      end
      cnest_pkg::CMD_EOF: begin
        if (nest_level != 0) r.error_code = cnest_pkg::ERR_OPEN;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Line numbers lean towards the extremes of the field.
  function automatic logic [cnest_pkg::LINE_W-1:0] pick_line();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return cnest_pkg::LINE_W'($urandom_range(0, 15));
      default: return cnest_pkg::LINE_W'($urandom);
    endcase
  endfunction

  // Queues one directive word and tracks the depth it leaves behind.
  task automatic add_directive(cnest_pkg::cmd_t c, logic cnd, logic nok,
                               logic [cnest_pkg::LINE_W-1:0] ln);
    cnest_pkg::dir_word_t w;
    w.cmd = c;
    w.cond = cnd;
    w.name_ok = nok;
    w.line_number = ln;
    directive_queue.push_back(w);
    if ((c == cnest_pkg::CMD_IF || c == cnest_pkg::CMD_IFDEF || c == cnest_pkg::CMD_IFNDEF)
        && gen_depth < cnest_pkg::NEST_DEPTH)
      gen_depth++;
    else if (c == cnest_pkg::CMD_ENDIF && gen_depth > 0)
      gen_depth--;
  endtask

  task automatic add_push();
    add_directive(cnest_pkg::cmd_t'($urandom_range(0, 2)), 1'($urandom),
                  $urandom_range(0, 9) != 0, pick_line());
  endtask

  task automatic add_branch(cnest_pkg::cmd_t c);
    add_directive(c, 1'($urandom), 1'($urandom), pick_line());
  endtask

  // One random word, mostly keeping the nesting well formed.
  task automatic add_random_word();
    int roll;
    int push_pct;
    roll = $urandom_range(0, 99);
    push_pct = (gen_depth < 6) ? 35 : 20;
    if (roll < push_pct) begin
      add_push();
    end else if (roll < push_pct + 15) begin
      add_branch(cnest_pkg::CMD_ELIF);
    end else if (roll < push_pct + 26) begin
      add_branch(cnest_pkg::CMD_ELSE);
    end else if (roll < push_pct + 50) begin
      // Stray closers on an empty stack are kept rare.
      if (gen_depth == 0 && $urandom_range(0, 4) != 0) add_push();
      else add_branch(cnest_pkg::CMD_ENDIF);
    end else if (roll < 97) begin
      add_branch(cnest_pkg::CMD_OTHER);
    end else begin
      add_branch(cnest_pkg::CMD_EOF);
    end
  endtask

  // Nests to the full depth, pushes past it, then unwinds to the top level.
  task automatic add_deep_nest();
    while (gen_depth < cnest_pkg::NEST_DEPTH) begin
      add_push();
      if ($urandom_range(0, 4) == 0) add_branch(cnest_pkg::cmd_t'($urandom_range(3, 6)));
    end
    add_directive(cnest_pkg::CMD_IFDEF, 1'b1, 1'b0, pick_line());
    add_directive(cnest_pkg::CMD_IF, 1'b1, 1'b1, pick_line());
    add_push();
    add_branch(cnest_pkg::CMD_EOF);
    add_branch(cnest_pkg::CMD_ELIF);
    add_branch(cnest_pkg::CMD_ELSE);
    while (gen_depth > 0) begin
      add_branch(cnest_pkg::CMD_ENDIF);
      if ($urandom_range(0, 4) == 0) add_branch(cnest_pkg::cmd_t'($urandom_range(3, 4)));
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    // Stray closers and end of file on an empty stack.
    add_directive(cnest_pkg::CMD_ENDIF, 1'b0, 1'b0, '0);
    add_directive(cnest_pkg::CMD_ELIF, 1'b1, 1'b1, '1);
    add_directive(cnest_pkg::CMD_ELSE, 1'b0, 1'b1, '0);
    add_directive(cnest_pkg::CMD_EOF, 1'b1, 1'b0, '1);
    add_directive(cnest_pkg::CMD_OTHER, 1'b1, 1'b1, 24'h5A5A5A);
    // Taken outer level, then a false level holding a missing identifier.
    add_directive(cnest_pkg::CMD_IF, 1'b1, 1'b0, '1);
    add_directive(cnest_pkg::CMD_IFDEF, 1'b0, 1'b1, 24'hA5A5A5);
    add_directive(cnest_pkg::CMD_OTHER, 1'b0, 1'b0, '0);
    add_directive(cnest_pkg::CMD_IFDEF, 1'b1, 1'b0, 24'h000100);
    add_directive(cnest_pkg::CMD_ELIF, 1'b0, 1'b1, 24'h000101);
    add_directive(cnest_pkg::CMD_ENDIF, 1'b1, 1'b1, 24'h000102);
    add_directive(cnest_pkg::CMD_ELIF, 1'b1, 1'b0, '1);
    add_directive(cnest_pkg::CMD_ELSE, 1'b0, 1'b0, 24'h000200);
    add_directive(cnest_pkg::CMD_ENDIF, 1'b0, 1'b1, '1);
    add_directive(cnest_pkg::CMD_EOF, 1'b0, 1'b1, '0);
    // ifndef taken, else into a false region with a nested level inside.
    add_directive(cnest_pkg::CMD_IFNDEF, 1'b0, 1'b1, 24'h000300);
    add_directive(cnest_pkg::CMD_ELSE, 1'b1, 1'b1, 24'h000301);
    add_directive(cnest_pkg::CMD_IF, 1'b1, 1'b1, 24'h000302);
    add_directive(cnest_pkg::CMD_ELSE, 1'b0, 1'b0, 24'h000303);
    add_directive(cnest_pkg::CMD_ENDIF, 1'b1, 1'b0, 24'h000304);
    add_directive(cnest_pkg::CMD_ENDIF, 1'b0, 1'b1, 24'hFFFFFE);
    add_directive(cnest_pkg::CMD_IFNDEF, 1'b1, 1'b1, 24'h000400);
    add_directive(cnest_pkg::CMD_ELIF, 1'b0, 1'b1, 24'h000401);
    add_directive(cnest_pkg::CMD_ELSE, 1'b1, 1'b0, 24'h000402);
    add_directive(cnest_pkg::CMD_ENDIF, 1'b0, 1'b0, 24'h000403);
    add_directive(cnest_pkg::CMD_ENDIF, 1'b1, 1'b1, 24'h000404);
    add_directive(cnest_pkg::CMD_EOF, 1'b0, 1'b0, '1);

    // Random part with two dives to the full stack depth.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3 || i == (2 * RANDOM_WORDS) / 3) add_deep_nest();
      add_random_word();
    end
    total_words = directive_queue.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted_words < total_words) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Directive driver: bursts of words with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      dir_valid <= 1'b0;
    end else if (!dir_valid || !dir_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        dir_valid <= 1'b0;
      end else if (directive_queue.size() != 0) begin
        dir_word <= directive_queue.pop_front();
        dir_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        dir_valid <= 1'b0;
      end
    end
  end

  // Result stall: the pattern switches at random among none, random, runs and toggle modes.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE: next_stall = 1'b0;
        STALL_RANDOM: next_stall = ($urandom_range(0, 3) == 0);
        STALL_RUNS: begin
          if (run_left > 0) begin
            run_left--;
            next_stall = res_stall;
          end else begin
            next_stall = ~res_stall;
            run_left = res_stall ? $urandom_range(0, 5) : $urandom_range(0, 11);
          end
        end
        default: next_stall = ~res_stall;
      endcase
      res_stall <= next_stall;
    end
  end

  // Monitor: check each result word, then predict for each accepted directive.
  always @(posedge clk) begin
    cnest_pkg::res_word_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with no directive outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_word.active !== want.active) begin
            $error("active: expected %0d, got %0d", want.active, res_word.active);
            fail_count++;
          end
          if (res_word.emit_newline !== want.emit_newline) begin
            $error("emit_newline: expected %0d, got %0d", want.emit_newline,
                   res_word.emit_newline);
            fail_count++;
          end
          if (res_word.emit_marker !== want.emit_marker) begin
            $error("emit_marker: expected %0d, got %0d", want.emit_marker,
                   res_word.emit_marker);
            fail_count++;
          end
          if (res_word.marker_line !== want.marker_line) begin
            $error("marker_line: expected %0h, got %0h", want.marker_line,
                   res_word.marker_line);
            fail_count++;
          end
          if (res_word.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code,
                   res_word.error_code);
            fail_count++;
          end
        end
      end
      if (dir_valid && !dir_stall) begin
        expected_results.push_back(predict_directive(dir_word));
        accepted_words++;
      end
    end
  end

endmodule
